// ===== rtl/core/i8080_instruction_subset_core_macros.svh =====
`ifndef I8080_INSTRUCTION_SUBSET_CORE_MACROS_SVH
`define I8080_INSTRUCTION_SUBSET_CORE_MACROS_SVH

// same-cycle implication
`define I8S_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define I8S_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/i8s_pkg.sv =====
package i8s_pkg;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_EXEC = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  localparam logic [7:0] OP_NOP  = 8'h00;
  localparam logic [7:0] OP_LXIB = 8'h01;
  localparam logic [7:0] OP_STAX = 8'h02;
  localparam logic [7:0] OP_INXB = 8'h03;
  localparam logic [7:0] OP_RLC  = 8'h07;
  localparam logic [7:0] OP_RRC  = 8'h0f;
  localparam logic [7:0] OP_CMA  = 8'h2f;
  localparam logic [7:0] OP_STA  = 8'h32;
  localparam logic [7:0] OP_MVIM = 8'h36;
  localparam logic [7:0] OP_STC  = 8'h37;
  localparam logic [7:0] OP_LDA  = 8'h3a;
  localparam logic [7:0] OP_CMC  = 8'h3f;
  localparam logic [7:0] OP_HLT  = 8'h76;
  localparam logic [7:0] OP_POPB = 8'hc1;
  localparam logic [7:0] OP_JNZ  = 8'hc2;
  localparam logic [7:0] OP_JMP  = 8'hc3;
  localparam logic [7:0] OP_CNZ  = 8'hc4;
  localparam logic [7:0] OP_PUSHB = 8'hc5;
  localparam logic [7:0] OP_ADI  = 8'hc6;
  localparam logic [7:0] OP_RZ   = 8'hc8;
  localparam logic [7:0] OP_RET  = 8'hc9;
  localparam logic [7:0] OP_JZ   = 8'hca;
  localparam logic [7:0] OP_CALL = 8'hcd;
  localparam logic [7:0] OP_POPD = 8'hd1;
  localparam logic [7:0] OP_JNC  = 8'hd2;
  localparam logic [7:0] OP_PUSHD = 8'hd5;
  localparam logic [7:0] OP_JC   = 8'hda;
  localparam logic [7:0] OP_CC   = 8'hdc;
  localparam logic [7:0] OP_POPH = 8'he1;
  localparam logic [7:0] OP_JPO  = 8'he2;
  localparam logic [7:0] OP_XTHL = 8'he3;
  localparam logic [7:0] OP_PUSHH = 8'he5;
  localparam logic [7:0] OP_ANI  = 8'he6;
  localparam logic [7:0] OP_XCHG = 8'heb;
  localparam logic [7:0] OP_POPP = 8'hf1;
  localparam logic [7:0] OP_PUSHP = 8'hf5;
  localparam logic [7:0] OP_SPHL = 8'hf9;
  localparam logic [7:0] OP_CPI  = 8'hfe;

  localparam logic [2:0] REG_M = 3'd6;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD, ST_READ, ST_RWAIT, ST_F0, ST_F1, ST_F2, ST_F3,
    ST_M0, ST_M1, ST_M2, ST_M3, ST_EXEC, ST_OUT
  } state_t;

  typedef enum logic [3:0] {
    ACC_NONE, ACC_LOAD, ACC_EXT_RD, ACC_F0, ACC_F1, ACC_F2, ACC_RD_ONE,
    ACC_RD_SP0, ACC_RD_SP1, ACC_WR_ONE, ACC_WR_PHI, ACC_WR_PLO, ACC_WR_XL, ACC_WR_XH
  } acc_t;

  typedef enum logic [2:0] {
    CL_NONE, CL_RDM, CL_WR1, CL_POP, CL_PUSH, CL_XTHL
  } cls_t;

  typedef struct packed {
    acc_t acc;
    logic exec;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [7:0] op;
    logic       z;
    logic       cy;
    logic       halt;
    logic       bad;
  } dp_stat_t;

  typedef struct packed {
    logic [7:0]  acc;
    logic [15:0] pair_bc;
    logic [15:0] pair_de;
    logic [15:0] pair_hl;
    logic [15:0] stack_ptr;
    logic [15:0] prog_counter;
    logic [4:0]  flag_bits;
    logic        halted;
    logic        bad_opcode;
    logic [7:0]  read_data;
  } out_t;

  function automatic logic is_call(logic [7:0] op);
    return (op == OP_CALL) || (op == OP_CNZ) || (op == OP_CC);
  endfunction

  function automatic cls_t op_class(logic [7:0] op, logic z, logic cy);
    cls_t c;
    c = CL_NONE;
    if (op == OP_HLT) begin
      c = CL_NONE;
    end else if (op[7:6] == 2'b01 && op[2:0] == REG_M) begin
      c = CL_RDM;
    end else if (op[7:6] == 2'b01 && op[5:3] == REG_M) begin
      c = CL_WR1;
    end else if (op[7:6] == 2'b10 && op[2:0] == REG_M) begin
      c = CL_RDM;
    end else if (op == OP_LDA) begin
      c = CL_RDM;
    end else if (op == OP_MVIM || op == OP_STAX || op == OP_STA) begin
      c = CL_WR1;
    end else if (op == OP_POPB || op == OP_POPD || op == OP_POPH || op == OP_POPP ||
                 op == OP_RET || (op == OP_RZ && z)) begin
      c = CL_POP;
    end else if (op == OP_PUSHB || op == OP_PUSHD || op == OP_PUSHH || op == OP_PUSHP ||
                 op == OP_CALL || (op == OP_CNZ && !z) || (op == OP_CC && cy)) begin
      c = CL_PUSH;
    end else if (op == OP_XTHL) begin
      c = CL_XTHL;
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/i8s_req_if.sv =====
interface i8s_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] address;
  logic [7:0]  load_data;

  modport source (output valid, output cmd, output address, output load_data, input ready);
  modport sink (input valid, input cmd, input address, input load_data, output ready);
endinterface

// ===== rtl/core/i8s_rsp_if.sv =====
interface i8s_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  acc;
  logic [15:0] pair_bc;
  logic [15:0] pair_de;
  logic [15:0] pair_hl;
  logic [15:0] stack_ptr;
  logic [15:0] prog_counter;
  logic [4:0]  flag_bits;
  logic        halted;
  logic        bad_opcode;
  logic [7:0]  read_data;

  modport source (output valid, output acc, output pair_bc, output pair_de, output pair_hl,
                  output stack_ptr, output prog_counter, output flag_bits, output halted,
                  output bad_opcode, output read_data, input ready);
  modport sink (input valid, input acc, input pair_bc, input pair_de, input pair_hl,
                input stack_ptr, input prog_counter, input flag_bits, input halted,
                input bad_opcode, input read_data, output ready);
endinterface

// ===== rtl/core/i8s_ctrl.sv =====
module i8s_ctrl
  import i8s_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_fire,
  input  logic [1:0] req_cmd,
  input  logic       rsp_ready,
  input  dp_stat_t   stat,
  output dp_cmd_t    cmd,
  output logic       req_ready,
  output logic       rsp_valid
);

  state_t state, state_next;
  cls_t   cls;

  assign cls = op_class(stat.op, stat.z, stat.cy);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_fire) begin
          if (req_cmd == CMD_LOAD) state_next = ST_LOAD;
          else if (req_cmd == CMD_READ) state_next = ST_READ;
          else if (req_cmd == CMD_EXEC && !stat.halt) state_next = ST_F0;
          else state_next = ST_OUT;
        end
      end
      ST_LOAD:  state_next = ST_OUT;
      ST_READ:  state_next = ST_RWAIT;
      ST_RWAIT: state_next = ST_OUT;
      ST_F0:    state_next = ST_F1;
      ST_F1:    state_next = ST_F2;
      ST_F2:    state_next = ST_F3;
      ST_F3:    state_next = (cls == CL_NONE) ? ST_EXEC : ST_M0;
      ST_M0:    state_next = (cls == CL_WR1) ? ST_EXEC : ST_M1;
      ST_M1:    state_next = (cls == CL_POP || cls == CL_XTHL) ? ST_M2 : ST_EXEC;
      ST_M2:    state_next = (cls == CL_XTHL) ? ST_M3 : ST_EXEC;
      ST_M3:    state_next = ST_EXEC;
      ST_EXEC:  state_next = ST_OUT;
      ST_OUT:   if (!rsp_valid || rsp_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.acc = ACC_NONE;
    cmd.exec = (state == ST_EXEC);
    cmd.out_load = (state == ST_OUT) && (!rsp_valid || rsp_ready);
    req_ready = (state == ST_IDLE);
    unique case (state)
      ST_LOAD: cmd.acc = ACC_LOAD;
      ST_READ: cmd.acc = ACC_EXT_RD;
      ST_F0:   cmd.acc = ACC_F0;
      ST_F1:   cmd.acc = ACC_F1;
      ST_F2:   cmd.acc = ACC_F2;
      ST_M0: begin
        unique case (cls)
          CL_RDM:  cmd.acc = ACC_RD_ONE;
          CL_WR1:  cmd.acc = ACC_WR_ONE;
          CL_POP:  cmd.acc = ACC_RD_SP0;
          CL_PUSH: cmd.acc = ACC_WR_PHI;
          CL_XTHL: cmd.acc = ACC_RD_SP0;
          default: cmd.acc = ACC_NONE;
        endcase
      end
      ST_M1: begin
        unique case (cls)
          CL_POP:  cmd.acc = ACC_RD_SP1;
          CL_PUSH: cmd.acc = ACC_WR_PLO;
          CL_XTHL: cmd.acc = ACC_RD_SP1;
          default: cmd.acc = ACC_NONE;
        endcase
      end
      ST_M2:   cmd.acc = (cls == CL_XTHL) ? ACC_WR_XL : ACC_NONE;
      ST_M3:   cmd.acc = ACC_WR_XH;
      default: cmd.acc = ACC_NONE;
    endcase
  end

endmodule

// ===== rtl/core/i8s_dpath.sv =====
module i8s_dpath
  import i8s_pkg::*;
#(
  parameter int ADDR_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_fire,
  input  logic [15:0] address,
  input  logic [7:0]  load_data,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  output out_t        out_q
);

  logic [7:0] mem [2**ADDR_BITS];
  logic [7:0] mem_q;
  logic [ADDR_BITS-1:0] maddr;
  logic [15:0] addr16;
  logic [7:0]  wdata;
  logic        is_wr, we;

  logic [15:0] rom_boundary;
  logic [15:0] in_addr;
  logic [7:0]  in_data;
  acc_t        cap_q;

  logic [7:0]  reg_a, reg_b, reg_c, reg_d, reg_e, reg_h, reg_l;
  logic [15:0] sp, pc;
  logic [4:0]  flags;
  logic        halt, bad;
  logic [7:0]  op, b1, b2, tmp_lo, tmp_hi, rbyte;

  logic [7:0]  reg_a_next, reg_b_next, reg_c_next, reg_d_next, reg_e_next, reg_h_next;
  logic [7:0]  reg_l_next;
  logic [15:0] sp_next, pc_next;
  logic [4:0]  flags_next;
  logic        halt_next, bad_next;

  logic [15:0] imm, bc, de, hl, pc1, pc2, pc3, push_w;
  logic [7:0]  src_val;
  logic [12:0] alu_r;

  function automatic logic [12:0] alu(logic [2:0] kind, logic [7:0] a, logic [7:0] v,
                                      logic [4:0] f);
    logic [8:0] r;
    logic [7:0] res;
    logic [4:0] fo;
    r = 9'd0;
    unique case (kind)
      3'd0: r = {1'b0, a} + {1'b0, v};
      3'd1: r = {1'b0, a} + {1'b0, v} + {8'd0, f[3]};
      3'd2: r = {1'b0, a} - {1'b0, v};
      3'd3: r = {1'b0, a} - {1'b0, v} - {8'd0, f[3]};
      3'd4: r = {1'b0, a & v};
      3'd5: r = {1'b0, a ^ v};
      3'd6: r = {1'b0, a | v};
      3'd7: r = {1'b0, a} - {1'b0, v};
      default: r = 9'd0;
    endcase
    res = r[7:0];
    fo = {f[4], r[8], ~^res, res[7], res == 8'h00};
    return {(kind == 3'd7) ? a : res, fo};
  endfunction

  assign imm = {b2, b1};
  assign bc = {reg_b, reg_c};
  assign de = {reg_d, reg_e};
  assign hl = {reg_h, reg_l};
  assign pc1 = pc + 16'd1;
  assign pc2 = pc + 16'd2;
  assign pc3 = pc + 16'd3;

  always_comb begin
    unique case (op[2:0])
      3'd0: src_val = reg_b;
      3'd1: src_val = reg_c;
      3'd2: src_val = reg_d;
      3'd3: src_val = reg_e;
      3'd4: src_val = reg_h;
      3'd5: src_val = reg_l;
      3'd6: src_val = tmp_lo;
      default: src_val = reg_a;
    endcase
  end

  always_comb begin
    if (is_call(op)) begin
      push_w = pc3;
    end else begin
      unique case (op[5:4])
        2'd0: push_w = bc;
        2'd1: push_w = de;
        2'd2: push_w = hl;
        default: push_w = {reg_a, 3'b000, flags};
      endcase
    end
  end

  always_comb begin
    addr16 = pc;
    wdata = src_val;
    is_wr = 1'b0;
    unique case (cmd.acc)
      ACC_LOAD:   begin addr16 = in_addr; wdata = in_data; end
      ACC_EXT_RD: addr16 = in_addr;
      ACC_F0:     addr16 = pc;
      ACC_F1:     addr16 = pc1;
      ACC_F2:     addr16 = pc2;
      ACC_RD_ONE: addr16 = (op == OP_LDA) ? imm : hl;
      ACC_RD_SP0: addr16 = sp;
      ACC_RD_SP1: addr16 = sp + 16'd1;
      ACC_WR_ONE: begin
        is_wr = 1'b1;
        addr16 = (op == OP_STAX) ? bc : ((op == OP_STA) ? imm : hl);
        if (op == OP_MVIM) wdata = b1;
        else if (op == OP_STAX || op == OP_STA) wdata = reg_a;
        else wdata = src_val;
      end
      ACC_WR_PHI: begin is_wr = 1'b1; addr16 = sp - 16'd1; wdata = push_w[15:8]; end
      ACC_WR_PLO: begin is_wr = 1'b1; addr16 = sp - 16'd2; wdata = push_w[7:0]; end
      ACC_WR_XL:  begin is_wr = 1'b1; addr16 = sp; wdata = reg_l; end
      ACC_WR_XH:  begin is_wr = 1'b1; addr16 = sp + 16'd1; wdata = reg_h; end
      default:    addr16 = pc;
    endcase
  end

  assign maddr = addr16[ADDR_BITS-1:0];
  assign we = (cmd.acc == ACC_LOAD) || (is_wr && (16'(maddr) >= rom_boundary));

  always_ff @(posedge clk) begin
    if (we) mem[maddr] <= wdata;
    mem_q <= mem[maddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rom_boundary <= 16'd0;
      cap_q <= ACC_NONE;
    end else begin
      if (cfg_we) rom_boundary <= cfg_data;
      if (cmd.acc == ACC_EXT_RD || cmd.acc == ACC_F0 || cmd.acc == ACC_F1 ||
          cmd.acc == ACC_F2 || cmd.acc == ACC_RD_ONE || cmd.acc == ACC_RD_SP0 ||
          cmd.acc == ACC_RD_SP1) begin
        cap_q <= cmd.acc;
      end else begin
        cap_q <= ACC_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      in_addr <= address;
      in_data <= load_data;
      rbyte <= 8'h00;
    end else if (cap_q == ACC_EXT_RD) begin
      rbyte <= mem_q;
    end
    unique case (cap_q)
      ACC_F0: op <= mem_q;
      ACC_F1: b1 <= mem_q;
      ACC_F2: b2 <= mem_q;
      ACC_RD_ONE, ACC_RD_SP0: tmp_lo <= mem_q;
      ACC_RD_SP1: tmp_hi <= mem_q;
      default: ;
    endcase
  end

  assign alu_r = alu((op[7:6] == 2'b10) ? op[5:3] :
                     ((op == OP_ADI) ? 3'd0 : ((op == OP_ANI) ? 3'd4 : 3'd7)),
                     reg_a, (op[7:6] == 2'b10) ? src_val : b1, flags);

  always_comb begin
    reg_a_next = reg_a;
    reg_b_next = reg_b;
    reg_c_next = reg_c;
    reg_d_next = reg_d;
    reg_e_next = reg_e;
    reg_h_next = reg_h;
    reg_l_next = reg_l;
    sp_next = sp;
    pc_next = pc1;
    flags_next = flags;
    halt_next = halt;
    bad_next = bad;
    if (op == OP_HLT) begin
      halt_next = 1'b1;
    end else if (op[7:6] == 2'b01 || (op[7:6] == 2'b00 && op[2:0] == 3'd6)) begin
      if (op[7:6] == 2'b00) pc_next = pc2;
      unique case (op[5:3])
        3'd0: reg_b_next = (op[7:6] == 2'b00) ? b1 : src_val;
        3'd1: reg_c_next = (op[7:6] == 2'b00) ? b1 : src_val;
        3'd2: reg_d_next = (op[7:6] == 2'b00) ? b1 : src_val;
        3'd3: reg_e_next = (op[7:6] == 2'b00) ? b1 : src_val;
        3'd4: reg_h_next = (op[7:6] == 2'b00) ? b1 : src_val;
        3'd5: reg_l_next = (op[7:6] == 2'b00) ? b1 : src_val;
        3'd6: ;
        default: reg_a_next = (op[7:6] == 2'b00) ? b1 : src_val;
      endcase
    end else if (op[7:6] == 2'b10) begin
      reg_a_next = alu_r[12:5];
      flags_next = alu_r[4:0];
    end else begin
      unique case (op)
        OP_NOP: ;
        OP_LXIB: begin reg_b_next = b2; reg_c_next = b1; pc_next = pc3; end
        OP_STAX: ;
        OP_INXB: {reg_b_next, reg_c_next} = bc + 16'd1;
        OP_RLC: begin reg_a_next = {reg_a[6:0], reg_a[7]}; flags_next[3] = reg_a[7]; end
        OP_RRC: begin reg_a_next = {reg_a[0], reg_a[7:1]}; flags_next[3] = reg_a[0]; end
        OP_CMA: reg_a_next = ~reg_a;
        OP_STA: pc_next = pc3;
        OP_STC: flags_next[3] = 1'b1;
        OP_LDA: begin reg_a_next = tmp_lo; pc_next = pc3; end
        OP_CMC: flags_next[3] = ~flags[3];
        OP_POPB: begin {reg_b_next, reg_c_next} = {tmp_hi, tmp_lo}; sp_next = sp + 16'd2; end
        OP_POPD: begin {reg_d_next, reg_e_next} = {tmp_hi, tmp_lo}; sp_next = sp + 16'd2; end
        OP_POPH: begin {reg_h_next, reg_l_next} = {tmp_hi, tmp_lo}; sp_next = sp + 16'd2; end
        OP_POPP: begin
          reg_a_next = tmp_hi;
          flags_next = tmp_lo[4:0];
          sp_next = sp + 16'd2;
        end
        OP_PUSHB, OP_PUSHD, OP_PUSHH, OP_PUSHP: sp_next = sp - 16'd2;
        OP_JMP: pc_next = imm;
        OP_JNZ: pc_next = !flags[0] ? imm : pc3;
        OP_JZ:  pc_next = flags[0] ? imm : pc3;
        OP_JNC: pc_next = !flags[3] ? imm : pc3;
        OP_JC:  pc_next = flags[3] ? imm : pc3;
        OP_JPO: pc_next = !flags[2] ? imm : pc3;
        OP_CALL, OP_CNZ, OP_CC: begin
          if (op == OP_CALL || (op == OP_CNZ && !flags[0]) || (op == OP_CC && flags[3])) begin
            pc_next = imm;
            sp_next = sp - 16'd2;
          end else begin
            pc_next = pc3;
          end
        end
        OP_RZ: begin
          if (flags[0]) begin
            pc_next = {tmp_hi, tmp_lo};
            sp_next = sp + 16'd2;
          end
        end
        OP_RET: begin pc_next = {tmp_hi, tmp_lo}; sp_next = sp + 16'd2; end
        OP_ADI, OP_ANI, OP_CPI: begin
          reg_a_next = alu_r[12:5];
          flags_next = alu_r[4:0];
          pc_next = pc2;
        end
        OP_XTHL: begin reg_h_next = tmp_hi; reg_l_next = tmp_lo; end
        OP_XCHG: begin
          {reg_h_next, reg_l_next} = de;
          {reg_d_next, reg_e_next} = hl;
        end
        OP_SPHL: sp_next = hl;
        default: begin
          halt_next = 1'b1;
          bad_next = 1'b1;
          pc_next = pc;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_a <= 8'd0;
      reg_b <= 8'd0;
      reg_c <= 8'd0;
      reg_d <= 8'd0;
      reg_e <= 8'd0;
      reg_h <= 8'd0;
      reg_l <= 8'd0;
      sp <= 16'd0;
      pc <= 16'd0;
      flags <= 5'd0;
      halt <= 1'b0;
      bad <= 1'b0;
    end else if (cmd.exec) begin
      reg_a <= reg_a_next;
      reg_b <= reg_b_next;
      reg_c <= reg_c_next;
      reg_d <= reg_d_next;
      reg_e <= reg_e_next;
      reg_h <= reg_h_next;
      reg_l <= reg_l_next;
      sp <= sp_next;
      pc <= pc_next;
      flags <= flags_next;
      halt <= halt_next;
      bad <= bad_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_q.acc <= reg_a;
      out_q.pair_bc <= bc;
      out_q.pair_de <= de;
      out_q.pair_hl <= hl;
      out_q.stack_ptr <= sp;
      out_q.prog_counter <= pc;
      out_q.flag_bits <= flags;
      out_q.halted <= halt;
      out_q.bad_opcode <= bad;
      out_q.read_data <= rbyte;
    end
  end

  assign stat.op = op;
  assign stat.z = flags[0];
  assign stat.cy = flags[3];
  assign stat.halt = halt;
  assign stat.bad = bad;

endmodule

// ===== rtl/core/i8080_instruction_subset_core.sv =====
// 8080 instruction subset core on a single-port internal memory of 2**ADDR_BITS bytes.
// One word in, one word out. Memory accesses take turns on the single port: a load
// writes its byte, a read reads one and waits for it, an execute always fetches three
// instruction bytes, makes zero to four data accesses and commits; each then answers.
// A halted core answers an execute with no fetch. The result waits in an output
// register; the next word may be accepted meanwhile. rom_boundary drops instruction
// writes below it; loads are never blocked. Memory contents are undefined until written.
`include "i8080_instruction_subset_core_macros.svh"

module i8080_instruction_subset_core
  import i8s_pkg::*;
#(
  parameter int ADDR_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  i8s_req_if.sink     req,
  i8s_rsp_if.source   rsp,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  out_t     out_q;
  logic     req_fire;

  assign req_fire = req.valid && req.ready;

  i8s_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_fire  (req_fire),
    .req_cmd   (req.cmd),
    .rsp_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid)
  );

  i8s_dpath #(.ADDR_BITS(ADDR_BITS)) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .req_fire  (req_fire),
    .address   (req.address),
    .load_data (req.load_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_q     (out_q)
  );

  assign rsp.acc = out_q.acc;
  assign rsp.pair_bc = out_q.pair_bc;
  assign rsp.pair_de = out_q.pair_de;
  assign rsp.pair_hl = out_q.pair_hl;
  assign rsp.stack_ptr = out_q.stack_ptr;
  assign rsp.prog_counter = out_q.prog_counter;
  assign rsp.flag_bits = out_q.flag_bits;
  assign rsp.halted = out_q.halted;
  assign rsp.bad_opcode = out_q.bad_opcode;
  assign rsp.read_data = out_q.read_data;

  `I8S_ASSERT_NEXT(a_busy_after_accept, clk, rst, req_fire, !req.ready, "ready after accept")
  `I8S_ASSERT_NEXT(a_halt_sticky, clk, rst, stat.halt, stat.halt, "halt dropped")
  `I8S_ASSERT_NOW(a_bad_halts, clk, rst, stat.bad, stat.halt, "bad opcode without halt")

endmodule
